@@ design/bdlp_pkg.sv @@
// Shared types and constants for the button debounce and long-press block.
package bdlp_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] DEFAULT_DEBOUNCE = 16'd50;

    localparam logic [CFG_INDEX_W-1:0] CFG_POL_INVERT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd2;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_PRESS = 2'd1,
        EV_RELEASE = 2'd2,
        EV_LONG = 2'd3
    } event_t;

    typedef struct packed {
        logic pol_invert;
        logic [COUNT_W-1:0] debounce_ticks;
        logic [COUNT_W-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        event_t ev;
        logic pressed;
        logic level;
    } tick_result_t;

endpackage

@@ design/bdlp_sample_if.sv @@
// Handshake channel that carries one raw pin sample per transaction.
interface bdlp_sample_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink (input valid, input pin_level, output ready);
endinterface

@@ design/bdlp_result_if.sv @@
// Handshake channel that carries one button result per transaction.
interface bdlp_result_if;
    logic valid;
    logic ready;
    logic [1:0] event_res;
    logic debounced_pressed;
    logic level_now;

    modport source (output valid, output event_res, output debounced_pressed,
                    output level_now, input ready);
    modport sink (input valid, input event_res, input debounced_pressed,
                  input level_now, output ready);
endinterface

@@ design/bdlp_tracker.sv @@
// Debounce and long-press state registers with their per-tick update logic.
module bdlp_tracker
    import bdlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  logic         pin_level,
    input  cfg_t         cfg,
    output tick_result_t result
);

    logic               prev_raw_reg, prev_raw_next;
    logic [COUNT_W-1:0] deb_rem_reg, deb_rem_next;
    logic               deb_armed_reg, deb_armed_next;
    logic               pressed_reg, pressed_next;
    logic [COUNT_W-1:0] hold_rem_reg, hold_rem_next;
    logic               hold_armed_reg, hold_armed_next;

    logic   level;
    logic   hold_fresh;
    event_t ev;

    always_comb
    begin
        level = pin_level ^ cfg.pol_invert;
        ev = EV_NONE;
        hold_fresh = 1'b0;
        prev_raw_next = pin_level;
        deb_rem_next = deb_rem_reg;
        deb_armed_next = deb_armed_reg;
        pressed_next = pressed_reg;
        hold_rem_next = hold_rem_reg;
        hold_armed_next = hold_armed_reg;

        if (pin_level != prev_raw_reg)
        begin
            deb_rem_next = (cfg.debounce_ticks != '0) ? cfg.debounce_ticks
                                                       : DEFAULT_DEBOUNCE;
            deb_armed_next = 1'b1;
        end
        else if (deb_armed_reg)
        begin
            if (deb_rem_reg <= 16'd1)
            begin
                deb_rem_next = '0;
                deb_armed_next = 1'b0;
                if (level != pressed_reg)
                begin
                    pressed_next = level;
                    if (level)
                    begin
                        ev = EV_PRESS;
                        if (cfg.long_press_ticks != '0)
                        begin
                            hold_rem_next = cfg.long_press_ticks;
                            hold_armed_next = 1'b1;
                            hold_fresh = 1'b1;
                        end
                    end
                    else
                    begin
                        ev = EV_RELEASE;
                        hold_rem_next = '0;
                        hold_armed_next = 1'b0;
                    end
                end
            end
            else
            begin
                deb_rem_next = deb_rem_reg - 16'd1;
            end
        end

        // A release above clears the hold, so only a live hold counts here.
        if (hold_armed_next && !hold_fresh)
        begin
            if (hold_rem_next <= 16'd1)
            begin
                hold_rem_next = '0;
                hold_armed_next = 1'b0;
                if (pressed_next && ev == EV_NONE)
                begin
                    ev = EV_LONG;
                end
            end
            else
            begin
                hold_rem_next = hold_rem_next - 16'd1;
            end
        end

        result.ev = ev;
        result.pressed = pressed_next;
        result.level = level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= 1'b0;
            deb_rem_reg <= '0;
            deb_armed_reg <= 1'b0;
            pressed_reg <= 1'b0;
            hold_rem_reg <= '0;
            hold_armed_reg <= 1'b0;
        end
        else if (step_en)
        begin
            prev_raw_reg <= prev_raw_next;
            deb_rem_reg <= deb_rem_next;
            deb_armed_reg <= deb_armed_next;
            pressed_reg <= pressed_next;
            hold_rem_reg <= hold_rem_next;
            hold_armed_reg <= hold_armed_next;
        end
    end

endmodule

@@ design/button_debounce_long_press_core.sv @@
// Top level of the button debounce and long-press block.
// Each sample transaction is one millisecond tick of the raw pin level and
// produces exactly one result transaction with the event (none, press,
// release or long press), the debounced pressed state and the
// polarity-corrected raw level. The block takes one sample per clock cycle
// unless a result waits untaken; the result is registered when the sample
// is accepted, and a new sample is taken in the same cycle that a waiting
// result is taken. Configuration writes are taken on any cycle with the
// write enable high and should be made while no transaction is in flight.
module button_debounce_long_press_core
    import bdlp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    bdlp_sample_if.sink            sample,
    bdlp_result_if.source          result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t         cfg_reg;
    logic         out_valid_reg;
    tick_result_t out_reg;
    tick_result_t tick_res;
    logic         step_en;

    assign sample.ready = !out_valid_reg || result.ready;
    assign step_en = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pol_invert <= 1'b0;
            cfg_reg.debounce_ticks <= DEFAULT_DEBOUNCE;
            cfg_reg.long_press_ticks <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POL_INVERT:       cfg_reg.pol_invert <= cfg_data[0];
                CFG_DEBOUNCE_TICKS:   cfg_reg.debounce_ticks <= cfg_data;
                CFG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_data;
                default:              ;
            endcase
        end
    end

    bdlp_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .pin_level (sample.pin_level),
        .cfg       (cfg_reg),
        .result    (tick_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_reg <= tick_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.event_res = out_reg.ev;
    assign result.debounced_pressed = out_reg.pressed;
    assign result.level_now = out_reg.level;

endmodule
